/* design/sha1_byte_stream_hasher_macros.svh */
// Assertion macros shared by the hasher RTL.
// Included by the top level; no other dependencies.
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH

`ifndef ASSERT_OFF
`define SHA1_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SHA1_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SHA1_ASSERT(lbl, clk, rstn, prop, msg)
`define SHA1_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* design/sha1_bsh_pkg.sv */
// Shared types and constants of the SHA-1 byte stream hasher.
// No dependencies; used by every module of the block.
package sha1_bsh_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NUM_W   = 16;
    localparam int unsigned NUM_H   = 5;
    localparam int unsigned ROUNDS  = 80;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [6:0]        rnd_t;
    typedef logic [5:0]        pos_t;
    typedef logic [60:0]       len_t;
    typedef logic [63:0]       bitlen_t;

    localparam rnd_t RND_LAST  = rnd_t'(ROUNDS - 1);
    localparam rnd_t RND_SCHED = rnd_t'(16);
    localparam rnd_t RND_PH1   = rnd_t'(20);
    localparam rnd_t RND_PH2   = rnd_t'(40);
    localparam rnd_t RND_PH3   = rnd_t'(60);

    localparam word_t K0 = 32'h5a82_7999;
    localparam word_t K1 = 32'h6ed9_eba1;
    localparam word_t K2 = 32'h8f1b_bcdc;
    localparam word_t K3 = 32'hca62_c1d6;

    localparam word_t H_INIT [NUM_H] = '{
        32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
    };

    localparam pos_t POS_FULL    = pos_t'(63);
    localparam pos_t POS_LEN_FIT = pos_t'(56);
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Control from the sequencer to the message schedule.
    typedef struct packed {
        logic load;       // write one message byte
        logic pad_first;  // 0x80 marker, zero fill, length if it fits
        logic pad_len;    // all-zero block carrying the length
        logic shift;      // advance one round
        logic early;      // rounds 0..15: replay stored words
    } sched_ctrl_t;

endpackage

/* design/sha1_bsh_round.sv */
// One SHA-1 round: round function, constant and five-term sum.
// Depends on sha1_bsh_pkg.
module sha1_bsh_round (
    input  sha1_bsh_pkg::word_t a_in,
    input  sha1_bsh_pkg::word_t b_in,
    input  sha1_bsh_pkg::word_t c_in,
    input  sha1_bsh_pkg::word_t d_in,
    input  sha1_bsh_pkg::word_t e_in,
    input  sha1_bsh_pkg::word_t w_in,
    input  sha1_bsh_pkg::rnd_t  rnd,
    output sha1_bsh_pkg::word_t a_out
);

    sha1_bsh_pkg::word_t f;
    sha1_bsh_pkg::word_t k;

    always_comb begin
        if (rnd < sha1_bsh_pkg::RND_PH1) begin
            f = (b_in & c_in) | (~b_in & d_in);
            k = sha1_bsh_pkg::K0;
        end else if (rnd < sha1_bsh_pkg::RND_PH2) begin
            f = b_in ^ c_in ^ d_in;
            k = sha1_bsh_pkg::K1;
        end else if (rnd < sha1_bsh_pkg::RND_PH3) begin
            f = (b_in & c_in) | (b_in & d_in) | (c_in & d_in);
            k = sha1_bsh_pkg::K2;
        end else begin
            f = b_in ^ c_in ^ d_in;
            k = sha1_bsh_pkg::K3;
        end
    end

    assign a_out = {a_in[26:0], a_in[31:27]} + f + e_in + k + w_in;

endmodule

/* design/sha1_bsh_sched.sv */
// Message block store and SHA-1 message schedule as a 16-word shift line.
// Packs bytes big-endian, applies padding and length. Depends on sha1_bsh_pkg.
module sha1_bsh_sched (
    input  logic                       aclk,
    input  sha1_bsh_pkg::sched_ctrl_t  ctrl,
    input  logic [7:0]                 byte_in,
    input  sha1_bsh_pkg::pos_t         pos,
    input  sha1_bsh_pkg::bitlen_t      bit_len,
    output sha1_bsh_pkg::word_t        w_out
);

    sha1_bsh_pkg::word_t w_reg  [sha1_bsh_pkg::NUM_W];
    sha1_bsh_pkg::word_t w_next [sha1_bsh_pkg::NUM_W];
    sha1_bsh_pkg::word_t w_new;
    logic [4:0]          lane_sh;

    assign w_new   = {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                      w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};
    assign w_out   = ctrl.early ? w_reg[0] : w_new;
    assign lane_sh = {~pos[1:0], 3'b000};

    always_comb begin
        logic [5:0] p;
        p = '0;
        w_next = w_reg;
        if (ctrl.load) begin
            w_next[pos[5:2]][lane_sh +: 8] = byte_in;
        end else if (ctrl.pad_first) begin
            for (int i = 0; i < 16; i++) begin
                for (int j = 0; j < 4; j++) begin
                    p = 6'(4 * i + j);
                    if (p == pos) begin
                        w_next[i][8 * (3 - j) +: 8] = sha1_bsh_pkg::PAD_BYTE;
                    end else if (p > pos) begin
                        w_next[i][8 * (3 - j) +: 8] = 8'h00;
                    end
                end
            end
            if (pos < sha1_bsh_pkg::POS_LEN_FIT) begin
                w_next[14] = bit_len[63:32];
                w_next[15] = bit_len[31:0];
            end
        end else if (ctrl.pad_len) begin
            for (int i = 0; i < 14; i++) begin
                w_next[i] = '0;
            end
            w_next[14] = bit_len[63:32];
            w_next[15] = bit_len[31:0];
        end else if (ctrl.shift) begin
            // early rounds rotate the block so it is back in place at round 16
            for (int i = 0; i < 15; i++) begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = w_out;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
    end

endmodule

/* design/sha1_byte_stream_hasher.sv */
// SHA-1 byte stream hasher top level: handshake, sequencer, chaining state.
// Depends on sha1_bsh_pkg, sha1_bsh_round, sha1_bsh_sched and the macro header.
//
// Feed the message one byte per transfer (s_tuser = byte present, s_tlast = end of
// message); a transfer with s_tuser low and s_tlast high closes an empty message.
// A byte that neither fills the block nor ends the message leaves s_tready high. The
// byte that fills a 64-byte block starts the compression: the single round unit runs
// the 80 rounds one per cycle, then the result is added into the chaining words, and
// s_tready stays low until that add is done. At end of message each of the one or
// two final compressions follows a padding step, then the five digest words leave
// on m_* most significant first, and the block is ready for the next message once
// the fifth word has been taken.
`include "sha1_byte_stream_hasher_macros.svh"

module sha1_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_number
    output logic        m_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FINAL = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;
    localparam logic [2:0] OUT_LAST = 3'd4;

    logic [2:0]                 state_reg, state_next;
    sha1_bsh_pkg::rnd_t         rnd_reg, rnd_next;
    sha1_bsh_pkg::pos_t         pos_reg, pos_next;
    sha1_bsh_pkg::len_t         len_reg, len_next;
    logic                       eom_pend_reg, eom_pend_next;
    logic                       pad_act_reg, pad_act_next;
    logic                       last_blk_reg, last_blk_next;
    logic [2:0]                 out_cnt_reg, out_cnt_next;
    sha1_bsh_pkg::word_t        h_reg [sha1_bsh_pkg::NUM_H];
    sha1_bsh_pkg::word_t        h_next [sha1_bsh_pkg::NUM_H];
    sha1_bsh_pkg::word_t        a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_bsh_pkg::word_t        a_next, b_next, c_next, d_next, e_next;
    sha1_bsh_pkg::word_t        a_round;
    sha1_bsh_pkg::word_t        w_t;
    sha1_bsh_pkg::sched_ctrl_t  sctrl;
    logic                       in_xfer, out_xfer, start_blk;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign out_xfer = m_tvalid && m_tready;
    assign m_tdata  = h_reg[0];
    assign m_tuser  = out_cnt_reg;
    assign m_tlast  = (out_cnt_reg == OUT_LAST);

    sha1_bsh_sched u_sched (
        .aclk    (aclk),
        .ctrl    (sctrl),
        .byte_in (s_tdata),
        .pos     (pos_reg),
        .bit_len ({len_reg, 3'b000}),
        .w_out   (w_t)
    );

    sha1_bsh_round u_round (
        .a_in  (a_reg),
        .b_in  (b_reg),
        .c_in  (c_reg),
        .d_in  (d_reg),
        .e_in  (e_reg),
        .w_in  (w_t),
        .rnd   (rnd_reg),
        .a_out (a_round)
    );

    always_comb begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        eom_pend_next = eom_pend_reg;
        pad_act_next  = pad_act_reg;
        last_blk_next = last_blk_reg;
        out_cnt_next  = out_cnt_reg;
        h_next        = h_reg;
        sctrl         = '0;
        sctrl.early   = (rnd_reg < sha1_bsh_pkg::RND_SCHED);
        start_blk     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser) begin
                        sctrl.load = 1'b1;
                        pos_next   = pos_reg + 6'd1;
                        len_next   = len_reg + 61'd1;
                        if (pos_reg == sha1_bsh_pkg::POS_FULL) begin
                            eom_pend_next = s_tlast;
                            start_blk     = 1'b1;
                            state_next    = ST_ROUND;
                        end else if (s_tlast) begin
                            state_next = ST_PAD;
                        end
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (pad_act_reg) begin
                    sctrl.pad_len = 1'b1;
                    last_blk_next = 1'b1;
                end else begin
                    sctrl.pad_first = 1'b1;
                    pad_act_next    = 1'b1;
                    last_blk_next   = (pos_reg < sha1_bsh_pkg::POS_LEN_FIT);
                end
                start_blk  = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                sctrl.shift = 1'b1;
                rnd_next    = rnd_reg + 7'd1;
                if (rnd_reg == sha1_bsh_pkg::RND_LAST) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                if (pad_act_reg) begin
                    if (last_blk_reg) begin
                        out_cnt_next = '0;
                        state_next   = ST_OUT;
                    end else begin
                        state_next = ST_PAD;
                    end
                end else if (eom_pend_reg) begin
                    eom_pend_next = 1'b0;
                    state_next    = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    // advance the next digest word into the output slot
                    for (int i = 0; i < 4; i++) begin
                        h_next[i] = h_reg[i + 1];
                    end
                    out_cnt_next = out_cnt_reg + 3'd1;
                    if (out_cnt_reg == OUT_LAST) begin
                        h_next        = sha1_bsh_pkg::H_INIT;
                        pos_next      = '0;
                        len_next      = '0;
                        pad_act_next  = 1'b0;
                        last_blk_next = 1'b0;
                        out_cnt_next  = '0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (start_blk) begin
            rnd_next = '0;
        end
    end

    // Working variables: load from the chain at block start, run a round in ST_ROUND, else hold.
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (start_blk) begin
            a_next = h_reg[0];
            b_next = h_reg[1];
            c_next = h_reg[2];
            d_next = h_reg[3];
            e_next = h_reg[4];
        end else if (sctrl.shift) begin
            a_next = a_round;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rnd_reg      <= '0;
            pos_reg      <= '0;
            len_reg      <= '0;
            eom_pend_reg <= 1'b0;
            pad_act_reg  <= 1'b0;
            last_blk_reg <= 1'b0;
            out_cnt_reg  <= '0;
            h_reg        <= sha1_bsh_pkg::H_INIT;
        end else begin
            state_reg    <= state_next;
            rnd_reg      <= rnd_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            eom_pend_reg <= eom_pend_next;
            pad_act_reg  <= pad_act_next;
            last_blk_reg <= last_blk_next;
            out_cnt_reg  <= out_cnt_next;
            h_reg        <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    `SHA1_ASSERT_NEVER(a_rdy_out, aclk, aresetn, s_tready && m_tvalid, "ready during digest")
    `SHA1_ASSERT(a_rdy_last, aclk, aresetn, out_xfer && m_tlast |=> s_tready, "not ready")
    `SHA1_ASSERT(a_word0, aclk, aresetn, $rose(m_tvalid) |-> m_tuser == 3'd0, "not word 0")
    `SHA1_ASSERT(a_fin_out, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg) == ST_FINAL, "no add")

endmodule

/* dv/sha1_byte_stream_hasher_tb.sv */
// Self-checking testbench for the SHA-1 byte stream hasher: streams messages byte by byte
// and compares every digest word against a SHA-1 predictor kept inside the bench.
// Depends on sha1_bsh_pkg and the sha1_byte_stream_hasher RTL.
module sha1_byte_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        sha1_bsh_pkg::word_t digest;
        logic [2:0]          num;
        logic                last;
    } digest_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    sha1_bsh_pkg::word_t hash_h [sha1_bsh_pkg::NUM_H];
    sha1_bsh_pkg::word_t msg_blk [sha1_bsh_pkg::NUM_W];
    sha1_bsh_pkg::pos_t  blk_pos;
    sha1_bsh_pkg::len_t  msg_len;

    digest_word_t digest_q [$];
    int  n_sent = 0;
    int  n_fail = 0;
    int  rx_hold = 0;
    bit  idle_en = 1'b1;

    sha1_byte_stream_hasher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic sha1_bsh_pkg::word_t rotl(sha1_bsh_pkg::word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic sha1_compress();
        sha1_bsh_pkg::word_t w [sha1_bsh_pkg::NUM_W];
        sha1_bsh_pkg::word_t a, b, c, d, e, f, k, tmp;
        int s;
        for (int i = 0; i < sha1_bsh_pkg::NUM_W; i++) w[i] = msg_blk[i];
        a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
        for (int t = 0; t < sha1_bsh_pkg::ROUNDS; t++) begin
            s = t % 16;
            if (t >= 16)
                w[s] = rotl(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = sha1_bsh_pkg::K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = sha1_bsh_pkg::K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_bsh_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha1_bsh_pkg::K3;
            end
            tmp = rotl(a, 5) + f + e + k + w[s];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
    endtask

    function automatic void put_byte(int pos, logic [7:0] val);
        msg_blk[pos / 4][(3 - pos % 4) * 8 +: 8] = val;
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < sha1_bsh_pkg::NUM_H; i++) hash_h[i] = sha1_bsh_pkg::H_INIT[i];
        blk_pos = '0;
        msg_len = '0;
    endfunction

    // Fold one accepted transfer into the running hash; on end of message pad,
    // finish and queue the five digest words.
    task automatic sha1_absorb(logic [7:0] data, logic valid, logic eom);
        sha1_bsh_pkg::bitlen_t nbits;
        int p;
        if (valid) begin
            put_byte(blk_pos, data);
            msg_len = msg_len + 1'b1;
            blk_pos = blk_pos + 1'b1;
            if (blk_pos == '0) sha1_compress();
        end
        if (!eom) return;
        nbits = {msg_len, 3'b000};
        p = blk_pos;
        put_byte(p, sha1_bsh_pkg::PAD_BYTE);
        for (int i = p + 1; i < 64; i++) put_byte(i, 8'h00);
        // no room for the length: flush this block and carry it in a zero block
        if (p + 1 > sha1_bsh_pkg::POS_LEN_FIT) begin
            sha1_compress();
            for (int i = 0; i < 14; i++) msg_blk[i] = '0;
        end
        msg_blk[14] = nbits[63:32];
        msg_blk[15] = nbits[31:0];
        sha1_compress();
        for (int i = 0; i < sha1_bsh_pkg::NUM_H; i++)
            digest_q.push_back('{hash_h[i], 3'(i), (i == sha1_bsh_pkg::NUM_H - 1)});
        restart_hash();
    endtask

    task automatic send_item(logic [7:0] data, logic valid, logic eom);
        // insert random idle gaps while idle_en is set
        while (idle_en && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= valid;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        sha1_absorb(data, valid, eom);
        n_sent++;
    endtask

    task automatic send_message(int len, bit eom_on_byte, bit noise);
        for (int i = 0; i < len; i++) begin
            // drop an empty transfer in now and then
            if (noise && $urandom_range(99) < 8) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, eom_on_byte && (i == len - 1));
        end
        if (!eom_on_byte || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (digest_q.size() != 0);
    endtask

    task automatic test_empty_message();
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_short_messages();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_empty_items();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    // lengths around the padding split and the full-block edge
    task automatic test_block_boundaries();
        send_message(55, 1'b1, 1'b0);
        send_message(56, 1'b0, 1'b0);
        send_message(64, 1'b1, 1'b0);
    endtask

    task automatic test_output_backpressure();
        rx_hold = 300;
        send_message(3, 1'b1, 1'b0);
        send_message(0, 1'b0, 1'b0);
        send_message(10, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_no_idle_burst();
        idle_en = 1'b0;
        for (int m = 0; m < 4; m++)
            send_message($urandom_range(0, 12), 1'($urandom_range(1)), 1'b0);
        send_message(60, 1'b1, 1'b0);
        idle_en = 1'b1;
    endtask

    task automatic test_random_messages(int target);
        int r;
        int len;
        while (n_sent < target) begin
            r = $urandom_range(99);
            if (r < 60)      len = $urandom_range(0, 12);
            else if (r < 88) len = $urandom_range(13, 50);
            else             len = $urandom_range(51, 130);
            send_message(len, 1'($urandom_range(1)), 1'b1);
            // pause the sender until the digest is out
            if ($urandom_range(99) < 10) wait_drained();
        end
    endtask

    // result checker and receiver
    always @(posedge aclk) begin
        digest_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest transfer: word %h number %0d", m_tdata, m_tuser);
                n_fail++;
            end else begin
                exp_w = digest_q.pop_front();
                if (m_tdata !== exp_w.digest) begin
                    $error("digest_word mismatch: expected %h, got %h", exp_w.digest, m_tdata);
                    n_fail++;
                end
                if (m_tuser !== exp_w.num) begin
                    $error("word_number mismatch: expected %0d, got %0d", exp_w.num, m_tuser);
                    n_fail++;
                end
                if (m_tlast !== exp_w.last) begin
                    $error("last_word mismatch: expected %0d, got %0d", exp_w.last, m_tlast);
                    n_fail++;
                end
            end
        end
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= !idle_en || ($urandom_range(99) >= 23);
        end
    end

    initial begin
        restart_hash();
        for (int i = 0; i < sha1_bsh_pkg::NUM_W; i++) msg_blk[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_message();
        test_short_messages();
        test_empty_items();
        test_block_boundaries();
        test_output_backpressure();
        test_no_idle_burst();
        test_random_messages(420);
        wait_drained();
        repeat (200) @(posedge aclk);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
